### hdl/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]    DEPTH_SUM  = (CNT_W + 1)'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(DEPTH - 1);

  localparam logic [2:0] CMD_PUSH_REAR  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_REAR   = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_DUMP       = 3'd4;

  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_DATA   = 2'd3;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
  } in_payload_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } out_payload_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic       take;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_last;
    logic       upd;
    logic       dump_adv;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       empty;
    logic       full;
    logic       dump_last;
    logic       out_free;
  } sts_t;

  function automatic logic [ADDR_W-1:0] wrap_slot(input logic [CNT_W:0] a);
    logic [CNT_W:0] r;
    r = (a >= DEPTH_SUM) ? (a - DEPTH_SUM) : a;
    return r[ADDR_W-1:0];
  endfunction

endpackage

### hdl/deq_ctrl.sv
module deq_ctrl
  import deq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_cmd,
  output logic       in_ready,
  input  sts_t       sts,
  output ctl_t       ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && (in_cmd <= CMD_DUMP)) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          if (sts.cmd != CMD_DUMP || sts.empty || sts.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    ctl             = '0;
    ctl.emit_status = ST_PUSHED;
    ctl.emit_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.take = in_valid;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          case (sts.cmd)
            CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
              ctl.emit        = 1'b1;
              ctl.emit_status = sts.full ? ST_FULL : ST_PUSHED;
              ctl.upd         = !sts.full;
            end
            CMD_POP_REAR, CMD_POP_FRONT: begin
              ctl.emit        = 1'b1;
              ctl.emit_status = sts.empty ? ST_EMPTY : ST_DATA;
              ctl.upd         = !sts.empty;
            end
            CMD_DUMP: begin
              ctl.emit = 1'b1;
              if (sts.empty) begin
                ctl.emit_status = ST_EMPTY;
              end else begin
                ctl.emit_status = ST_DATA;
                ctl.emit_last   = sts.dump_last;
                ctl.dump_adv    = !sts.dump_last;
              end
            end
            default: ctl.emit = 1'b0;
          endcase
        end
      end
      default: ctl = '0;
    endcase
  end

endmodule

### hdl/deq_dp.sv
module deq_dp
  import deq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  in_payload_t  in_data,
  input  ctl_t         ctl,
  output sts_t         sts,
  output logic         out_valid,
  input  logic         out_ready,
  output out_payload_t out_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [2:0]               cmd_r;
  logic signed [DATA_W-1:0] value_r;
  logic [ADDR_W-1:0]        front_r;
  logic [CNT_W-1:0]         occ_r;
  logic [CNT_W-1:0]         idx_r;
  logic [DATA_W-1:0]        rd_q_r;
  logic                     out_valid_r;
  out_payload_t             out_r;

  logic [CNT_W-1:0]  rd_off;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] front_dec;
  logic [ADDR_W-1:0] front_inc;
  logic [ADDR_W-1:0] rear_slot;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;
  logic [CNT_W-1:0]  idx_inc;

  assign idx_inc   = idx_r + CNT_W'(1);
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - ADDR_W'(1);
  assign front_inc = wrap_slot({1'b0, CNT_W'(front_r)} + (CNT_W + 1)'(1));
  assign rear_slot = wrap_slot({1'b0, CNT_W'(front_r)} + {1'b0, occ_r});

  always_comb begin
    if (ctl.dump_adv) begin
      rd_off = idx_inc;
    end else if (in_data.command == CMD_POP_REAR) begin
      rd_off = occ_r - CNT_W'(1);
    end else begin
      rd_off = '0;
    end
  end

  assign rd_addr = wrap_slot({1'b0, CNT_W'(front_r)} + {1'b0, rd_off});
  assign rd_en   = ctl.take || ctl.dump_adv;

  assign wr_en   = ctl.upd && (cmd_r == CMD_PUSH_REAR || cmd_r == CMD_PUSH_FRONT);
  assign wr_addr = (cmd_r == CMD_PUSH_FRONT) ? front_dec : rear_slot;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r   <= in_data.command;
      value_r <= in_data.value;
      idx_r   <= '0;
    end else if (ctl.dump_adv) begin
      idx_r <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      occ_r   <= '0;
    end else if (ctl.upd) begin
      case (cmd_r)
        CMD_PUSH_REAR: occ_r <= occ_r + CNT_W'(1);
        CMD_PUSH_FRONT: begin
          front_r <= front_dec;
          occ_r   <= occ_r + CNT_W'(1);
        end
        CMD_POP_REAR: occ_r <= occ_r - CNT_W'(1);
        CMD_POP_FRONT: begin
          front_r <= front_inc;
          occ_r   <= occ_r - CNT_W'(1);
        end
        default: occ_r <= occ_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_r.status <= ctl.emit_status;
      out_r.data   <= (ctl.emit_status == ST_DATA) ? rd_q_r : '0;
      out_r.last   <= ctl.emit_last;
    end
  end

  assign sts.cmd       = cmd_r;
  assign sts.empty     = (occ_r == '0);
  assign sts.full      = (occ_r == DEPTH_CNT);
  assign sts.dump_last = (idx_inc == occ_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n) occ_r <= DEPTH_CNT)
    else $error("occupancy above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= LAST_SLOT)
    else $error("front pointer out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> sts.out_free)
    else $error("result loaded over a pending transfer");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !sts.full)
    else $error("write into a full store");

  a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dump_adv |-> (idx_inc < occ_r))
    else $error("dump ran past the rear");

endmodule

### hdl/double_ended_queue.sv
// Channel   Ports                          Payload
// input     in_valid / in_ready            in_data  : command, value
// result    out_valid / out_ready          out_data : status, data, last
//
// A push or a pop is accepted together with its memory read, then its result is
// loaded once the output register is free; the store has a registered read.
// A dump delivers one entry per cycle while the result channel does not stall.
// rst_n is synchronous; the store needs no clearing and the block is ready
// right after reset. A stalled result holds in the output register while the
// next transfer on the input side is still accepted.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_payload_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output out_payload_t out_data
);

  ctl_t ctl;
  sts_t sts;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.command),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  deq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/testbench.sv
module testbench
  import deq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
  localparam int RANDOM_ITEMS    = 100;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = DEPTH + 16;
  localparam int MAX_REPORTS     = 10;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  in_payload_t  in_data = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  out_payload_t out_data;

  double_ended_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow deque
  logic signed [DATA_W-1:0] deque_store [DEPTH];
  logic [ADDR_W-1:0]        head_slot = '0;
  logic [CNT_W-1:0]         fill_count = '0;
  out_payload_t             pending_results [$];

  int mismatches = 0;
  int results_checked = 0;
  int push_count = 0;
  int pop_count = 0;
  int dump_count = 0;
  int ignored_count = 0;
  int full_hits = 0;
  int empty_hits = 0;
  int peak_fill = 0;
  int burst_left = 0;

  bit         hold_off_req = 1'b0;
  int         hold_left = 0;
  int         hold_offs = 0;
  int         epoch_left = 0;
  int         stall_mode = 0;
  logic [7:0] stall_mask = '1;
  logic [2:0] pat_idx = '0;
  logic       ready_next;

  function automatic void add_result(input logic [1:0] st, input logic signed [DATA_W-1:0] d,
                                     input logic l);
    out_payload_t r;
    r.status = st;
    r.data   = d;
    r.last   = l;
    pending_results.push_back(r);
  endfunction

  function automatic void apply_command(input logic [2:0] cmd,
                                        input logic signed [DATA_W-1:0] val);
    int slot;
    case (cmd)
      CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
        push_count++;
        if (fill_count == DEPTH_CNT) begin
          full_hits++;
          add_result(ST_FULL, '0, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_REAR) begin
            slot = (int'(head_slot) + int'(fill_count)) % DEPTH;
          end else begin
            head_slot = ADDR_W'((int'(head_slot) + DEPTH - 1) % DEPTH);
            slot = int'(head_slot);
          end
          deque_store[slot] = val;
          fill_count++;
          if (int'(fill_count) > peak_fill) peak_fill = int'(fill_count);
          add_result(ST_PUSHED, '0, 1'b1);
        end
      end
      CMD_POP_REAR, CMD_POP_FRONT: begin
        pop_count++;
        if (fill_count == '0) begin
          empty_hits++;
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (cmd == CMD_POP_REAR) begin
            slot = (int'(head_slot) + int'(fill_count) - 1) % DEPTH;
          end else begin
            slot = int'(head_slot);
            head_slot = ADDR_W'((int'(head_slot) + 1) % DEPTH);
          end
          fill_count--;
          add_result(ST_DATA, deque_store[slot], 1'b1);
        end
      end
      CMD_DUMP: begin
        dump_count++;
        if (fill_count == '0) begin
          empty_hits++;
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int k = 0; k < int'(fill_count); k++) begin
            add_result(ST_DATA, deque_store[(int'(head_slot) + k) % DEPTH],
                       k == int'(fill_count) - 1);
          end
        end
      end
      default: begin
        ignored_count++;
      end
    endcase
  endfunction

  // predict on each input transfer before checking any output transfer of the same edge
  always @(posedge clk) begin
    out_payload_t want;
    if (rst_n) begin
      if (in_valid && in_ready) apply_command(in_data.command, in_data.value);
      if (out_valid && out_ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR %0t: unexpected result status %0d data %0h last %0b",
                     $realtime, out_data.status, out_data.data, out_data.last);
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status || out_data.data !== want.data ||
              out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("ERROR %0t: want status %0d data %0h last %0b, got status %0d data %0h last %0b",
                       $realtime, want.status, want.data, want.last,
                       out_data.status, out_data.data, out_data.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      ready_next = 1'b0;
      hold_left--;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HOLD_OFF_CYCLES - 1;
      hold_offs++;
      ready_next = 1'b0;
    end else begin
      if (epoch_left == 0) begin
        epoch_left = $urandom_range(20, 120);
        stall_mode = $urandom_range(0, 3);
        stall_mask = 8'($urandom);
      end
      epoch_left--;
      pat_idx++;
      case (stall_mode)
        0: ready_next = 1'b1;
        1: ready_next = stall_mask[pat_idx];
        2: ready_next = ($urandom_range(0, 3) != 0);
        default: ready_next = 1'($urandom_range(0, 1));
      endcase
    end
    out_ready <= ready_next;
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // mode 0 grows the deque, mode 1 drains it, mode 2 keeps it balanced
  function automatic logic [2:0] pick_command(input int mode);
    int r;
    int push_pct;
    r = $urandom_range(0, 99);
    push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
    if (r < 3) return 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    if (r < 7) return CMD_DUMP;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic signed [DATA_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= in_payload_t'{command: cmd, value: val};
    burst_left--;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic test_empty_deque();
    send_item(CMD_POP_REAR, pick_value());
    send_item(CMD_POP_FRONT, pick_value());
    send_item(CMD_DUMP, pick_value());
    for (int c = int'(CMD_FIRST_UNUSED); c <= int'(CMD_LAST_UNUSED); c++) begin
      send_item(3'(c), '1);
    end
  endtask

  task automatic test_extreme_values();
    send_item(CMD_PUSH_REAR, 32'sh7fff_ffff);
    send_item(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_item(CMD_PUSH_REAR, -32'sd1);
    send_item(CMD_PUSH_FRONT, 32'sd0);
    send_item(CMD_PUSH_REAR, 32'sh5555_5555);
    send_item(CMD_PUSH_FRONT, 32'shaaaa_aaaa);
    send_item(CMD_DUMP, '0);
    send_item(CMD_POP_REAR, '0);
    send_item(CMD_POP_FRONT, '1);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_REAR, '1);
    send_item(CMD_DUMP, '1);
    send_item(CMD_POP_REAR, '0);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_FRONT, '0);
  endtask

  task automatic test_full_and_wrap();
    repeat (DEPTH)
      send_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value());
    send_item(CMD_PUSH_REAR, pick_value());
    send_item(CMD_PUSH_FRONT, pick_value());
    send_item(CMD_DUMP, pick_value());
    repeat (DEPTH)
      send_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR, pick_value());
  endtask

  task automatic test_random_mix();
    int sent;
    int phase;
    int mode;
    int len;
    logic [2:0] cmd;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(8, 40);
      if (phase == 1) begin
        mode = 0;
        hold_off_req = 1'b1;
      end
      repeat (len) begin
        cmd = pick_command(mode);
        send_item(cmd, pick_value());
        if (cmd < CMD_FIRST_UNUSED) sent++;
      end
      phase++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_deque();
    test_extreme_values();
    test_full_and_wrap();
    test_random_mix();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d pushes, %0d pops, %0d dumps, %0d ignored codes; %0d results checked",
             push_count, pop_count, dump_count, ignored_count, results_checked);
    $display("Full rejects %0d, empty answers %0d, peak fill %0d, output hold-offs %0d, errors %0d",
             full_hits, empty_hits, peak_fill, hold_offs, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ERROR: run timed out with %0d results outstanding", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
